[hdl/ppc_pkg.sv]
// Shared types, constants and letter arithmetic for the polyalphabetic cipher.
package ppc_pkg;

  localparam int LETTER_W      = 5;
  localparam int SLOT_W        = 4;
  localparam int POS_W         = 4;
  localparam int LEN_W         = 5;
  localparam int KIND_W        = 2;
  localparam int MODE_W        = 2;
  localparam int REG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;
  localparam int ALPHA         = 26;
  localparam int KEY_SLOTS_DEF = 16;

  localparam logic [KIND_W-1:0] KIND_VIG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEAU = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VAR  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AUTO  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROG  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_KIND = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIR  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEN  = 2'd3;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              dec;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  function automatic letter_t red26(input letter_t v);
    return (v >= letter_t'(ALPHA)) ? letter_t'(v - letter_t'(ALPHA)) : v;
  endfunction

  function automatic letter_t neg26(input letter_t v);
    return (v == '0) ? '0 : letter_t'(letter_t'(ALPHA) - v);
  endfunction

  function automatic letter_t inc26(input letter_t v);
    return (v >= letter_t'(ALPHA - 1)) ? '0 : letter_t'(v + letter_t'(1));
  endfunction

  function automatic letter_t dec26(input letter_t v);
    return (v == '0) ? letter_t'(ALPHA - 1) : letter_t'(v - letter_t'(1));
  endfunction

endpackage

[hdl/ppc_cipher_alu.sv]
// Letter arithmetic: output letter, key shift update and key conversion on load.
module ppc_cipher_alu (
  input  ppc_pkg::cfg_t    cfg_i,
  input  logic             op_i,
  input  ppc_pkg::letter_t letter_i,
  input  ppc_pkg::letter_t shift_i,
  output ppc_pkg::letter_t res_o,
  output logic             upd_en_o,
  output ppc_pkg::letter_t upd_data_o
);
  import ppc_pkg::*;

  letter_t          l;
  letter_t          plain;
  letter_t          load_shift;
  logic             beau;
  logic             flip;
  logic             neg_load;
  logic [LETTER_W:0] sum;

  always_comb begin
    l        = red26(letter_i);
    beau     = (cfg_i.kind == KIND_BEAU);
    flip     = cfg_i.dec && !beau;
    neg_load = (cfg_i.kind == KIND_VAR) ? !cfg_i.dec : cfg_i.dec;
    if (beau) begin
      sum = (LETTER_W+1)'(letter_t'(ALPHA - 1) - l) + (LETTER_W+1)'(shift_i);
    end else begin
      sum = (LETTER_W+1)'(l) + (LETTER_W+1)'(shift_i);
    end
    res_o = (sum >= (LETTER_W+1)'(ALPHA)) ? letter_t'(sum - (LETTER_W+1)'(ALPHA))
                                           : letter_t'(sum);
    plain = cfg_i.dec ? res_o : l;
    if (beau) begin
      load_shift = inc26(l);
    end else begin
      load_shift = neg_load ? neg26(l) : l;
    end

    upd_en_o   = 1'b0;
    upd_data_o = load_shift;
    if (op_i == OP_LOAD) begin
      upd_en_o = 1'b1;
    end else begin
      case (cfg_i.mode)
        MODE_AUTO: begin
          upd_en_o   = 1'b1;
          upd_data_o = flip ? neg26(plain) : plain;
        end
        MODE_PROG: begin
          upd_en_o   = 1'b1;
          upd_data_o = flip ? dec26(shift_i) : inc26(shift_i);
        end
        default: begin
          upd_en_o = 1'b0;
        end
      endcase
    end
  end

endmodule

[hdl/periodic_polyalphabetic_cipher.sv]
// Top level of the periodic polyalphabetic cipher with its key shift memory.
//
// Input beats on the s_axis channel carry either a key letter to load into a
// slot (tuser low) or a text letter to encipher or decipher (tuser high).
// Each text beat gives one output beat on m_axis; a load beat gives none.
// The mode registers are written through the cfg port; the user must write
// them only while no beat is in flight, as the block does not enforce it.
// A text beat passes from the memory read stage to the output register, which
// drives m_axis. Throughput is one beat per cycle while m_axis does not stall,
// set by the single read-modify-write of the key shift memory; a write back is
// forwarded to a read of the same slot issued in the same cycle.
// Reset clears the key position, the mode registers and all valid flags; the
// key memory is not cleared and every slot in use must be loaded first.
// When m_axis stalls, the output register holds its beat, one more beat waits
// in the memory read stage, and tready then drops until the output drains.
module periodic_polyalphabetic_cipher #(
  parameter int KEY_SLOTS = ppc_pkg::KEY_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ppc_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] key_slot, [8:4] letter
  input  logic [15:0]                       s_axis_tdata,
  // [0] opcode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [4:0] out_letter
  output logic [7:0]                        m_axis_tdata
);
  import ppc_pkg::*;

  localparam int IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  cfg_t             cfg_q;
  logic [LEN_W-1:0] len_q;
  logic [POS_W-1:0] pos_q, pos_d;

  letter_t mem [KEY_SLOTS];

  logic            in_fire;
  logic [SLOT_W-1:0] in_slot;
  letter_t         in_letter;
  logic            in_op;
  logic [IdxW-1:0] rd_idx;
  logic            in_ld_ok;

  logic            s1_valid_q, s1_op_q, s1_ld_ok_q, fwd_q;
  letter_t         s1_letter_q, rdata_q, fwd_data_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_adv;
  logic            wr_en;
  letter_t         shift;
  letter_t         res, upd_data;
  logic            upd_en;

  logic            out_valid_q;
  letter_t         out_letter_q;

  int              eff_len;
  int              next_pos;

  assign in_slot   = s_axis_tdata[SLOT_W-1:0];
  assign in_letter = s_axis_tdata[SLOT_W+LETTER_W-1:SLOT_W];
  assign in_op     = s_axis_tuser;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  assign s1_adv        = s1_valid_q && ((s1_op_q == OP_LOAD) || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_comb begin
    in_ld_ok = (32'(in_slot) < KEY_SLOTS);
    if (in_op == OP_LOAD) begin
      rd_idx = IdxW'(in_slot);
    end else begin
      rd_idx = (32'(pos_q) < KEY_SLOTS) ? IdxW'(pos_q) : '0;
    end
    eff_len  = (len_q == '0) ? 1 : ((32'(len_q) > KEY_SLOTS) ? KEY_SLOTS : 32'(len_q));
    next_pos = 32'(pos_q) + 1;
    pos_d    = pos_q;
    if (in_fire) begin
      if (in_op == OP_LOAD) begin
        if (in_ld_ok) begin
          pos_d = '0;
        end
      end else begin
        pos_d = (next_pos >= eff_len) ? '0 : POS_W'(next_pos);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind <= KIND_VIG;
      cfg_q.dec  <= 1'b0;
      cfg_q.mode <= MODE_FIXED;
      len_q      <= LEN_W'(1);
      pos_q      <= '0;
    end else begin
      pos_q <= pos_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KIND: cfg_q.kind <= cfg_wdata_i[KIND_W-1:0];
          REG_DIR:  cfg_q.dec  <= cfg_wdata_i[0];
          REG_MODE: cfg_q.mode <= cfg_wdata_i[MODE_W-1:0];
          REG_LEN:  len_q      <= cfg_wdata_i[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  ppc_cipher_alu u_alu (
    .cfg_i      (cfg_q),
    .op_i       (s1_op_q),
    .letter_i   (s1_letter_q),
    .shift_i    (shift),
    .res_o      (res),
    .upd_en_o   (upd_en),
    .upd_data_o (upd_data)
  );

  assign shift = fwd_q ? fwd_data_q : rdata_q;
  assign wr_en = s1_adv && upd_en && ((s1_op_q != OP_LOAD) || s1_ld_ok_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_idx_q] <= upd_data;
    end
    if (in_fire) begin
      rdata_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && (s1_op_q == OP_TEXT)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= in_op;
      s1_letter_q <= in_letter;
      s1_idx_q    <= rd_idx;
      s1_ld_ok_q  <= in_ld_ok;
      fwd_q       <= wr_en && (s1_idx_q == rd_idx);
      fwd_data_q  <= upd_data;
    end
    if (s1_adv && (s1_op_q == OP_TEXT)) begin
      out_letter_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 8'(out_letter_q);

`ifndef SYNTH
  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_op == OP_LOAD) && in_ld_ok) |=> (pos_q == '0))
    else $error("key load did not restart the key position");

  a_text_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_op_q == OP_TEXT)) |=> out_valid_q)
    else $error("text beat left the read stage without an output beat");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  a_no_lost_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_letter_q)))
    else $error("stalled output beat was overwritten");
`endif

endmodule

[bench/ppc_checker.sv]
// Checker that predicts the cipher's output letters and compares them with the m_axis beats.
`timescale 1ns / 1ps
module ppc_checker #(
  parameter int KEY_SLOTS = ppc_pkg::KEY_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ppc_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [15:0]                    in_data_i,
  input  logic                           in_user_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [7:0]                     out_data_i,
  output int                             errors_o,
  output int                             pending_o
);
  import ppc_pkg::*;

  logic [KIND_W-1:0] kind_q;
  logic              dec_q;
  logic [MODE_W-1:0] mode_q;
  logic [LEN_W-1:0]  len_q;
  letter_t           shift_q [KEY_SLOTS];
  int                pos_q;
  letter_t           expected_letters [$];

  function automatic int mod26(input int v);
    return ((v % ALPHA) + ALPHA) % ALPHA;
  endfunction

  function automatic int key_to_shift(input int k);
    if (kind_q == KIND_BEAU) return mod26(k + 1);
    if (kind_q == KIND_VAR) return dec_q ? k : mod26(-k);
    return dec_q ? mod26(-k) : k;
  endfunction

  function automatic int period();
    if (len_q == '0) return 1;
    if (int'(len_q) > KEY_SLOTS) return KEY_SLOTS;
    return int'(len_q);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    int      ltr;
    int      shift;
    int      res;
    int      plain;
    int      nxt;
    int      slot;
    letter_t want;
    if (!rst_ni) begin
      kind_q = KIND_VIG;
      dec_q = 1'b0;
      mode_q = MODE_FIXED;
      len_q = LEN_W'(1);
      pos_q = 0;
      expected_letters.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KIND: kind_q = cfg_wdata_i[KIND_W-1:0];
          REG_DIR:  dec_q = cfg_wdata_i[0];
          REG_MODE: mode_q = cfg_wdata_i[MODE_W-1:0];
          REG_LEN:  len_q = cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        ltr = mod26(int'(in_data_i[8:4]));
        if (in_user_i == OP_LOAD) begin
          slot = int'(in_data_i[3:0]);
          if (slot < KEY_SLOTS) begin
            shift_q[slot] = letter_t'(key_to_shift(ltr));
            pos_q = 0;
          end
        end else begin
          slot = (pos_q < KEY_SLOTS) ? pos_q : 0;
          shift = mod26(int'(shift_q[slot]));
          if (kind_q == KIND_BEAU) res = mod26(ALPHA - 1 - ltr + shift);
          else res = mod26(ltr + shift);
          plain = dec_q ? res : ltr;
          if (mode_q == MODE_AUTO) begin
            shift_q[slot] = letter_t'((kind_q != KIND_BEAU && dec_q) ? mod26(-plain) : plain);
          end else if (mode_q == MODE_PROG) begin
            shift_q[slot] = letter_t'((kind_q != KIND_BEAU && dec_q) ? mod26(shift - 1)
                                                                      : mod26(shift + 1));
          end
          nxt = pos_q + 1;
          pos_q = (nxt >= period()) ? 0 : (nxt % 16);
          expected_letters.push_back(letter_t'(res));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_letters.size() == 0) begin
          $error("out_letter: unexpected beat, actual %0d", out_data_i[4:0]);
          errors_o++;
        end else begin
          want = expected_letters.pop_front();
          if (out_data_i[4:0] != want) begin
            $error("out_letter: expected %0d, actual %0d", want, out_data_i[4:0]);
            errors_o++;
          end
        end
      end
    end
    pending_o = expected_letters.size();
  end

endmodule

[bench/tb_periodic_polyalphabetic_cipher.sv]
// Testbench top that drives key loads, text letters and mode writes into the cipher.
`timescale 1ns / 1ps
module tb_periodic_polyalphabetic_cipher;
  import ppc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int LEN_TOP      = 31;
  localparam int ITEM_TARGET  = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_GAP      = 16;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [REG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;

  int errors;
  int pending;
  int sent;
  bit sender_quiet;
  bit hold_request;

  periodic_polyalphabetic_cipher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  ppc_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_valid_i(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_i (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL periodic_polyalphabetic_cipher");
    $finish;
  end

  initial begin : sink
    int gap;
    bit sink_quiet;
    m_axis_tready = 1'b0;
    sink_quiet = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 23) == 0) sink_quiet = !sink_quiet;
      gap = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_beat(input logic op, input int slot, input int ltr);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, ltr[LETTER_W-1:0], slot[SLOT_W-1:0]};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int kind, input int dec, input int mode, input int len);
    write_reg(REG_KIND, kind);
    write_reg(REG_DIR, dec);
    write_reg(REG_MODE, mode);
    write_reg(REG_LEN, len);
  endtask

  initial begin : stimulus
    int phase;
    int len;
    int n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_LOAD;
    sent = 0;
    sender_quiet = 1'b0;
    hold_request = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_config(KIND_VIG, 0, MODE_FIXED, KEY_SLOTS_DEF);
    for (int s = 0; s < KEY_SLOTS_DEF; s++) send_beat(OP_LOAD, s, (s * 7 + 25) % 32);
    send_beat(OP_TEXT, 0, 0);
    send_beat(OP_TEXT, 15, 25);
    send_beat(OP_TEXT, 5, 26);
    send_beat(OP_TEXT, 10, 31);
    settle();
    set_config(KIND_SPARE, 1, MODE_SPARE, 0);
    send_beat(OP_TEXT, 0, 5);
    send_beat(OP_TEXT, 0, 30);
    settle();
    set_config(KIND_BEAU, 1, MODE_AUTO, LEN_TOP);
    send_beat(OP_TEXT, 0, 12);
    send_beat(OP_TEXT, 0, 25);
    settle();

    phase = 0;
    while (sent < ITEM_TARGET) begin
      phase++;
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = $urandom_range(KEY_SLOTS_DEF + 1, LEN_TOP);
        2: len = KEY_SLOTS_DEF;
        default: len = $urandom_range(1, KEY_SLOTS_DEF);
      endcase
      set_config($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 3), len);
      sender_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, KEY_SLOTS_DEF);
        repeat (n) send_beat(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 31));
      end
      if (phase % 10 == 3) begin
        hold_request = 1'b1;
        sender_quiet = 1'b1;
      end
      n = $urandom_range(10, 60);
      repeat (n) begin
        if ($urandom_range(0, 15) == 0)
          send_beat(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 31));
        else
          send_beat(OP_TEXT, $urandom_range(0, 15), $urandom_range(0, 31));
      end
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("PASS periodic_polyalphabetic_cipher");
    end else begin
      $display("FAIL periodic_polyalphabetic_cipher");
    end
    $finish;
  end

endmodule
